// ===== hdl/mshb_pkg.sv =====
// Shared constants, queue word layout and back-end state codes for the byte hash unit.
package mshb_pkg;

   localparam logic [31:0] MIX_MUL    = 32'h5BD1E995;
   localparam logic [31:0] SEED_RESET = 32'hEE6B27EB;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One queue word: what the back end has to do for one accepted byte.
   typedef struct packed {
      logic        start;
      logic [31:0] seed_len;
      logic        word_en;
      logic [31:0] word;
      logic        finish;
      logic [23:0] tail;
      logic [1:0]  tail_cnt;
   } hash_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_K1,
      ST_K2,
      ST_K3,
      ST_H1,
      ST_H2,
      ST_TAIL,
      ST_T2,
      ST_RX,
      ST_RM,
      ST_OUT
   } back_state_type;

endpackage

// ===== hdl/murmur_style_64bit_byte_hash_unit.sv =====
// Byte-serial 64-bit hash unit: front end, work queue and multiply back end.
// Throughput: one byte word per cycle while the queue has room; the back end handles each
// completed 4-byte word in one pop step and five multiply steps on its 32x32 multiplier.
// Once the queue ahead is drained, the hash of a message follows its last byte through the
// pop, the five-step word mix if that byte ends a word, one or two tail steps, four finish
// rounds of an RX and an RM step each, and the output step. Reset is synchronous, active
// high, and restores the default seed and empties all stages.
module murmur_style_64bit_byte_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_byte_valid,
   input  logic        req_is_last,
   input  logic [15:0] req_message_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value
);
   import mshb_pkg::*;

   // The front end classifies each accepted word: a message start carries the seed xor
   // length, a fourth byte carries a completed little-endian word, and a last byte carries
   // the leftover tail bytes. Only words that need back-end work enter the queue, so bytes
   // in the middle of a word take no queue slot, though they are held too while it is full.
   logic        push, queue_full, queue_empty, pop;
   hash_op_type push_op, head_op;

   mshb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_value     (req_byte_value),
      .req_byte_valid     (req_byte_valid),
      .req_is_last        (req_is_last),
      .req_message_length (req_message_length),
      .push               (push),
      .push_op            (push_op),
      .queue_full         (queue_full)
   );

   // The queue decouples the two sides, so bytes keep streaming while the back end is busy
   // mixing a word or holding a finished hash that the consumer has not taken yet.
   mshb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (pop),
      .empty   (queue_empty),
      .head_op (head_op)
   );

   // The back end does every 64-bit multiply on one shared multiplier, as two 32x32 partial
   // products (one for a 32-bit block word), and owns the output register for the result word.
   mshb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .head_op        (head_op),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

// ===== hdl/mshb_front.sv =====
// Front end: takes message bytes, assembles 32-bit words and builds back-end work words.
module mshb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [31:0]          csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_byte_value,
   input  logic                 req_byte_valid,
   input  logic                 req_is_last,
   input  logic [15:0]          req_message_length,
   output logic                 push,
   output mshb_pkg::hash_op_type push_op,
   input  logic                 queue_full
);
   import mshb_pkg::*;

   logic [31:0] seed_ff;
   logic        in_msg_ff, in_msg_in;
   logic [23:0] part_ff, part_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        accept;
   logic [23:0] part_base;
   logic [1:0]  cnt_base;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      part_base = in_msg_ff ? part_ff : 24'h0;
      cnt_base  = in_msg_ff ? cnt_ff  : 2'd0;
      part_in   = part_base;
      cnt_in    = cnt_base;

      push_op          = '0;
      push_op.start    = !in_msg_ff;
      push_op.seed_len = seed_ff ^ {16'h0, req_message_length};

      if (req_byte_valid) begin
         if (cnt_base == 2'd3) begin
            push_op.word_en = 1'b1;
            push_op.word    = {req_byte_value, part_base};
            part_in         = 24'h0;
            cnt_in          = 2'd0;
         end else begin
            case (cnt_base)
               2'd0:    part_in[7:0]   = req_byte_value;
               2'd1:    part_in[15:8]  = req_byte_value;
               default: part_in[23:16] = req_byte_value;
            endcase
            cnt_in = cnt_base + 2'd1;
         end
      end

      push_op.finish   = req_is_last;
      push_op.tail     = part_in;
      push_op.tail_cnt = cnt_in;
      in_msg_in        = !req_is_last;

      push = accept && (push_op.start || push_op.word_en || push_op.finish);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= SEED_RESET;
         in_msg_ff <= 1'b0;
         part_ff   <= 24'h0;
         cnt_ff    <= 2'd0;
      end else begin
         if (csr_write_enable) begin
            seed_ff <= csr_write_data;
         end
         if (accept) begin
            in_msg_ff <= in_msg_in;
            part_ff   <= part_in;
            cnt_ff    <= cnt_in;
         end
      end
   end

endmodule

// ===== hdl/mshb_queue.sv =====
// Small register queue that carries work words from the front end to the back end.
module mshb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mshb_pkg::hash_op_type push_op,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output mshb_pkg::hash_op_type head_op
);
   import mshb_pkg::*;

   hash_op_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]        count_ff;
   logic                     do_push, do_pop;

   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/mshb_back.sv =====
// Back end: word mixing, tail and finish rounds on one shared 32x32 multiplier.
module mshb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  mshb_pkg::hash_op_type head_op,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [63:0]           rsp_hash_value
);
   import mshb_pkg::*;

   back_state_type state_ff, state_in;
   hash_op_type    op_ff, op_in;
   logic [63:0]    h1_ff, h1_in, h2_ff, h2_in;
   logic [63:0]    k_ff, k_in, acc_ff, acc_in;
   logic           parity_ff, parity_in;
   logic [1:0]     rnd_ff, rnd_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_hash_ff, rsp_hash_in;

   logic [31:0]    mul_a;
   logic [63:0]    mul_p;
   logic [63:0]    hi_term;
   logic [63:0]    tgt, mix, tailx, rx;

   function automatic logic [63:0] sext8(input logic [7:0] b);
      return {{56{b[7]}}, b};
   endfunction

   function automatic logic [63:0] asr(input logic [63:0] x, input logic [1:0] r);
      logic [63:0] res;
      case (r)
         2'd0:    res = 64'($signed(x) >>> 18);
         2'd1:    res = 64'($signed(x) >>> 22);
         2'd2:    res = 64'($signed(x) >>> 17);
         default: res = 64'($signed(x) >>> 19);
      endcase
      return res;
   endfunction

   assign mul_p          = 64'(mul_a) * 64'(MIX_MUL);
   assign hi_term        = {mul_p[31:0], 32'h0};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      parity_in    = parity_ff;
      rnd_in       = rnd_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;
      mul_a        = 32'h0;
      tgt          = parity_ff ? h2_ff : h1_ff;
      mix          = k_ff ^ 64'($signed(k_ff) >>> 24);
      tailx        = sext8(op_ff.tail[7:0]);
      if (op_ff.tail_cnt >= 2'd2) begin
         tailx = tailx ^ (sext8(op_ff.tail[15:8]) << 8);
      end
      if (op_ff.tail_cnt == 2'd3) begin
         tailx = tailx ^ (sext8(op_ff.tail[23:16]) << 16);
      end
      rx = rnd_ff[0] ? (h2_ff ^ asr(h1_ff, rnd_ff)) : (h1_ff ^ asr(h2_ff, rnd_ff));

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop   = 1'b1;
               op_in = head_op;
               if (head_op.start) begin
                  h1_in     = {32'h0, head_op.seed_len};
                  h2_in     = 64'h0;
                  parity_in = 1'b0;
               end
               if (head_op.word_en) begin
                  state_in = ST_K1;
               end else if (head_op.finish) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_K1: begin
            mul_a    = op_ff.word;
            k_in     = mul_p;
            state_in = ST_K2;
         end
         ST_K2: begin
            mul_a    = mix[31:0];
            k_in     = mix;
            acc_in   = mul_p;
            state_in = ST_K3;
         end
         ST_K3: begin
            mul_a    = k_ff[63:32];
            k_in     = acc_ff + hi_term;
            state_in = ST_H1;
         end
         ST_H1: begin
            mul_a    = tgt[31:0];
            acc_in   = mul_p;
            state_in = ST_H2;
         end
         ST_H2: begin
            mul_a = tgt[63:32];
            if (parity_ff) begin
               h2_in = (acc_ff + hi_term) ^ k_ff;
            end else begin
               h1_in = (acc_ff + hi_term) ^ k_ff;
            end
            parity_in = !parity_ff;
            state_in  = op_ff.finish ? ST_TAIL : ST_IDLE;
         end
         ST_TAIL: begin
            rnd_in = 2'd0;
            if (op_ff.tail_cnt != 2'd0) begin
               mul_a    = 32'(h2_ff ^ tailx);
               h2_in    = h2_ff ^ tailx;
               acc_in   = mul_p;
               state_in = ST_T2;
            end else begin
               state_in = ST_RX;
            end
         end
         ST_T2: begin
            mul_a    = h2_ff[63:32];
            h2_in    = acc_ff + hi_term;
            state_in = ST_RX;
         end
         ST_RX: begin
            mul_a  = rx[31:0];
            acc_in = mul_p;
            if (rnd_ff[0]) begin
               h2_in = rx;
            end else begin
               h1_in = rx;
            end
            state_in = ST_RM;
         end
         ST_RM: begin
            if (rnd_ff[0]) begin
               mul_a = h2_ff[63:32];
               h2_in = acc_ff + hi_term;
            end else begin
               mul_a = h1_ff[63:32];
               h1_in = acc_ff + hi_term;
            end
            if (rnd_ff == 2'd3) begin
               state_in = ST_OUT;
            end else begin
               rnd_in   = rnd_ff + 2'd1;
               state_in = ST_RX;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = {h1_ff[31:0] | h2_ff[63:32], h2_ff[31:0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         parity_ff    <= 1'b0;
         rnd_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         parity_ff    <= parity_in;
         rnd_ff       <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      h1_ff       <= h1_in;
      h2_ff       <= h2_in;
      k_ff        <= k_in;
      acc_ff      <= acc_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

// ===== tb/murmur_style_64bit_byte_hash_unit_tb.sv =====
// Self-checking testbench for the byte-serial 64-bit hash unit with its own hash predictor.
module murmur_style_64bit_byte_hash_unit_tb;

   import mshb_pkg::*;

   // The run is ended by the watchdog if it ever gets this far. A correct run needs far fewer
   // cycles, even with every byte waiting out the longest sender gap and every hash word
   // waiting out the longest receiver stall.
   localparam int unsigned CYCLE_LIMIT = 250000;
   // Quiet cycles allowed after the last hash word, a margin for any work still in flight.
   localparam int unsigned SETTLE_CYCLES = 24;
   // Length of the long receiver hold-off used to back the unit up to its input.
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   // Byte words sent in each random traffic phase.
   localparam int unsigned PHASE_WORDS = 500;

   // Every input starts at a known value, with reset asserted from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = 32'h0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = 8'h0;
   logic        req_byte_valid = 1'b0;
   logic        req_is_last = 1'b0;
   logic [15:0] req_message_length = 16'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_hash_value;

   // Idle rates in percent for the sender and the receiver, changed per phase.
   int unsigned send_idle_pct = 32;
   int unsigned rsp_idle_pct = 67;

   // The main sequence asks for a receiver hold-off by bumping hold_asked; the stall process
   // notices the difference and counts the hold-off down on its own.
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;

   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned words_accepted = 0;
   int unsigned hashes_seen = 0;
   int unsigned seed_writes = 0;
   int unsigned input_held_cycles = 0;

   // Hash values predicted for accepted messages, oldest first.
   logic [63:0] expected_hashes[$];

   // Predictor state: the seed register copy and the per-message accumulators.
   logic [31:0] seed_shadow = SEED_RESET;
   logic [63:0] acc_h1 = 64'h0;
   logic [63:0] acc_h2 = 64'h0;
   logic [23:0] tail_bytes = 24'h0;
   logic [1:0]  tail_count = 2'd0;
   logic        word_toggle = 1'b0;
   logic        msg_open = 1'b0;

   murmur_style_64bit_byte_hash_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_value     (req_byte_value),
      .req_byte_valid     (req_byte_valid),
      .req_is_last        (req_is_last),
      .req_message_length (req_message_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hash_value     (rsp_hash_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------------------------
   // Hash predictor. All arithmetic wraps at 64 bits and every right shift propagates the sign.
   // ------------------------------------------------------------------------------------------

   function automatic logic [63:0] times_mix(input logic [63:0] x);
      return x * {32'h0, MIX_MUL};
   endfunction

   function automatic logic [63:0] shift_signed(input logic [63:0] x, input int unsigned n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] widen_byte(input logic [7:0] b);
      return {{56{b[7]}}, b};
   endfunction

   // Advances the predictor by one accepted byte word and queues a hash when it ends a message.
   task automatic hash_track_byte(input logic [7:0] b, input logic has_data, input logic last,
                                  input logic [15:0] len);
      logic [63:0] k;
      logic [63:0] h1;
      logic [63:0] h2;
      // The first word of a message seeds the first accumulator. The length field is only
      // 16 bits wide and is zero-extended before it is XORed with the seed.
      if (!msg_open) begin
         acc_h1 = {32'h0, seed_shadow ^ {16'h0, len}};
         acc_h2 = 64'h0;
         tail_bytes = 24'h0;
         tail_count = 2'd0;
         word_toggle = 1'b0;
         msg_open = 1'b1;
      end
      if (has_data) begin
         if (tail_count == 2'd3) begin
            // Fourth byte completes a little-endian 32-bit block.
            k = times_mix({32'h0, b, tail_bytes});
            k = k ^ shift_signed(k, 24);
            k = times_mix(k);
            if (!word_toggle)
               acc_h1 = times_mix(acc_h1) ^ k;
            else
               acc_h2 = times_mix(acc_h2) ^ k;
            word_toggle = ~word_toggle;
            tail_bytes = 24'h0;
            tail_count = 2'd0;
         end else begin
            tail_bytes[8 * tail_count +: 8] = b;
            tail_count = tail_count + 2'd1;
         end
      end
      if (last) begin
         h1 = acc_h1;
         h2 = acc_h2;
         // Leftover bytes are sign-extended before they are folded into the second state.
         if (tail_count != 2'd0) begin
            if (tail_count == 2'd3)
               h2 ^= widen_byte(tail_bytes[23:16]) << 16;
            if (tail_count >= 2'd2)
               h2 ^= widen_byte(tail_bytes[15:8]) << 8;
            h2 ^= widen_byte(tail_bytes[7:0]);
            h2 = times_mix(h2);
         end
         h1 = times_mix(h1 ^ shift_signed(h2, 18));
         h2 = times_mix(h2 ^ shift_signed(h1, 22));
         h1 = times_mix(h1 ^ shift_signed(h2, 17));
         h2 = times_mix(h2 ^ shift_signed(h1, 19));
         // The halves overlap on purpose: the second state is ORed in at full width.
         expected_hashes.push_back((h1 << 32) | h2);
         msg_open = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------------------------------
   // Driving and checking.
   // ------------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      mismatch_count++;
      $display("MISMATCH cycle %0d: %s expected %016h got %016h", cycle_count, what, want, got);
   endtask

   // Offers one byte word and returns at the clock edge that accepted it. Valid is left high
   // so that back-to-back words need only one assignment per step; idle gaps lower it first.
   // The stall is sampled at the falling edge, where it is settled for the coming rising edge.
   task automatic push_byte(input logic [7:0] b, input logic has_data, input logic last,
                            input logic [15:0] len);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_byte_valid <= has_data;
      req_is_last <= last;
      req_message_length <= len;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      words_accepted++;
      hash_track_byte(b, has_data, last, len);
   endtask

   // Drops valid, waits for every predicted hash, then lets the unit settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_hashes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called while the unit is quiet; the predictor takes the new seed at once.
   task automatic write_seed(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      seed_shadow = value;
      seed_writes++;
      @(posedge clock);
   endtask

   // One well-formed message with random content. Most messages are short, some are long
   // enough to cycle the word parity many times. The length field usually matches the bytes
   // sent, but is sometimes random or pinned to an extreme. Data-less words are sprinkled in
   // as noise, and some messages end on a data-less word. Length fields after the first word
   // are random, since the unit must ignore them.
   task automatic send_random_message();
      int unsigned n_bytes;
      int unsigned i;
      int unsigned pick;
      logic [15:0] len_field;
      bit started;
      bit spare_end;
      pick = $urandom_range(99);
      if (pick < 80)
         n_bytes = $urandom_range(12, 0);
      else if (pick < 95)
         n_bytes = $urandom_range(40, 13);
      else
         n_bytes = $urandom_range(200, 41);
      pick = $urandom_range(9);
      if (pick < 7)
         len_field = 16'(n_bytes);
      else if (pick < 9)
         len_field = 16'($urandom);
      else
         len_field = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      spare_end = (n_bytes != 0) && ($urandom_range(9) == 0);
      started = 1'b0;
      if (n_bytes == 0)
         push_byte(8'($urandom), 1'b0, 1'b1, len_field);
      for (i = 0; i < n_bytes; i++) begin
         if ($urandom_range(19) == 0) begin
            push_byte(8'($urandom), 1'b0, 1'b0, started ? 16'($urandom) : len_field);
            started = 1'b1;
         end
         push_byte(8'($urandom), 1'b1, (i == n_bytes - 1) && !spare_end,
                   started ? 16'($urandom) : len_field);
         started = 1'b1;
      end
      if (spare_end)
         push_byte(8'($urandom), 1'b0, 1'b1, 16'($urandom));
   endtask

   // Receiver: random stalls at the current rate, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left <= HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Checks each hash word that the coming rising edge will accept against the oldest
   // prediction. Sampling at the falling edge keeps the check clear of the edge itself.
   always @(negedge clock) begin : hash_checker
      logic [63:0] want;
      if (!reset) begin
         if (req_valid && req_stall)
            input_held_cycles++;
         if (rsp_valid && !rsp_stall) begin
            hashes_seen++;
            if (expected_hashes.size() == 0) begin
               report_mismatch("hash word with nothing pending", 64'h0, rsp_hash_value);
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_hash_value !== want)
                  report_mismatch("hash_value", want, rsp_hash_value);
            end
         end
      end
   end

   // Watchdog: a hang or a lost hash word ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d hashes pending.", cycle_count,
                  expected_hashes.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------------------------

   // Hand-picked messages under the reset seed: empty messages at both length extremes,
   // sign-extended tails of one, two and three bytes, a tail-free full block, a message that
   // opens with a data-less word, and a length field that disagrees with the bytes sent.
   task automatic test_directed_cases();
      push_byte(8'h00, 1'b0, 1'b1, 16'h0000);
      push_byte(8'hFF, 1'b0, 1'b1, 16'hFFFF);
      push_byte(8'h80, 1'b1, 1'b1, 16'd1);
      push_byte(8'h7F, 1'b1, 1'b0, 16'd3);
      push_byte(8'h80, 1'b1, 1'b0, 16'h1234);
      push_byte(8'hFF, 1'b1, 1'b1, 16'h0000);
      push_byte(8'h00, 1'b1, 1'b0, 16'd2);
      push_byte(8'hFF, 1'b1, 1'b1, 16'd2);
      repeat (3) push_byte(8'hFF, 1'b1, 1'b0, 16'd4);
      push_byte(8'hFF, 1'b1, 1'b1, 16'd4);
      // The data-less opener still latches the length of 5.
      push_byte(8'hAA, 1'b0, 1'b0, 16'd5);
      push_byte(8'h01, 1'b1, 1'b0, 16'hFFFF);
      push_byte(8'h02, 1'b1, 1'b0, 16'hFFFF);
      push_byte(8'h03, 1'b1, 1'b0, 16'hFFFF);
      push_byte(8'h04, 1'b1, 1'b0, 16'hFFFF);
      push_byte(8'h05, 1'b1, 1'b1, 16'hFFFF);
      // Claims 1000 bytes, delivers two and closes on a data-less word.
      push_byte(8'h55, 1'b1, 1'b0, 16'd1000);
      push_byte(8'hAA, 1'b1, 1'b0, 16'd0);
      push_byte(8'h3C, 1'b0, 1'b1, 16'd0);
      drain_results();
   endtask

   // A seed written while a message is open must only apply from the next message on.
   task automatic test_seed_mid_message();
      push_byte(8'h12, 1'b1, 1'b0, 16'd5);
      push_byte(8'h34, 1'b1, 1'b0, 16'd5);
      drain_results();
      write_seed(32'h0000_0001);
      push_byte(8'h56, 1'b1, 1'b0, 16'd7);
      push_byte(8'h78, 1'b1, 1'b0, 16'd7);
      push_byte(8'h9A, 1'b1, 1'b1, 16'd7);
      push_byte(8'hBC, 1'b1, 1'b1, 16'd1);
      drain_results();
   endtask

   // Both extremes of the seed register, each with a handful of random messages.
   task automatic test_seed_extremes();
      write_seed(32'h0000_0000);
      repeat (6) send_random_message();
      drain_results();
      write_seed(32'hFFFF_FFFF);
      repeat (6) send_random_message();
      drain_results();
   endtask

   // A phase of random messages under a fresh random seed and the given idle rates.
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
      int unsigned first_word;
      send_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      write_seed($urandom);
      first_word = words_accepted;
      while (words_accepted - first_word < PHASE_WORDS)
         send_random_message();
      drain_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering words at full
   // rate, so work words pile up in the queue behind a held hash until the input stalls.
   task automatic test_output_backpressure();
      int unsigned first_word;
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_asked <= hold_asked + 1;
      first_word = words_accepted;
      while (words_accepted - first_word < 120)
         send_random_message();
      drain_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_seed_mid_message();
      test_seed_extremes();
      test_random_traffic(32, 67);
      test_random_traffic(67, 32);
      test_random_traffic(0, 0);
      test_output_backpressure();
      drain_results();

      $display("Hashed %0d messages from %0d byte words under %0d seed settings.",
               hashes_seen, words_accepted, seed_writes + 1);
      $display("Input was held off for %0d cycles; %0d mismatches found.",
               input_held_cycles, mismatch_count);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mshb_pkg.sv
hdl/mshb_front.sv
hdl/mshb_queue.sv
hdl/mshb_back.sv
hdl/murmur_style_64bit_byte_hash_unit.sv
tb/murmur_style_64bit_byte_hash_unit_tb.sv
